// ===== rtl/smc_pkg.sv =====
// Package: opcode and status codes for the stack machine core.
package smc_pkg;

    typedef enum logic [7:0] {
        OPC_NOP    = 8'h00,
        OPC_BIPUSH = 8'h10,
        OPC_POP    = 8'h57,
        OPC_DUP    = 8'h59,
        OPC_SWAP   = 8'h5F,
        OPC_IADD   = 8'h60,
        OPC_ISUB   = 8'h64,
        OPC_IAND   = 8'h7E,
        OPC_IOR    = 8'hB0,
        OPC_IN     = 8'hFC,
        OPC_OUT    = 8'hFD,
        OPC_ERR    = 8'hFE,
        OPC_HALT   = 8'hFF
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ERR      = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    localparam int unsigned DATA_W = 32;

endpackage

// ===== rtl/smc_stack_ram.sv =====
// Stack entry memory: one write port, one registered read port, write-first forwarding.
module smc_stack_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] q_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        q_reg        <= mem[raddr];
        fwd_reg      <= we && (waddr == raddr);
        fwd_data_reg <= wdata;
    end

    assign rdata = fwd_reg ? fwd_data_reg : q_reg;

endmodule

// ===== rtl/stack_machine_core_unit.sv =====
// Top level: IJVM-subset stack machine, one instruction per item.
// The result of an item is registered into the output register in the cycle after acceptance.
// Throughput: one item per cycle while the output is not stalled; top two entries live in registers, the third entry is
// read from the stack memory at the address set by the next stack pointer each cycle.
// Reset clears the stack pointer, halt state and output valid; stack memory is not cleared.
module stack_machine_core_unit #(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_kind,
    input  logic signed [7:0]                   s_operand,
    input  logic [7:0]                          s_in_char,
    input  logic                                s_in_eof,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_out_valid,
    output logic [7:0]                          m_out_char,
    output logic signed [smc_pkg::DATA_W-1:0]   m_top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0]    m_depth,
    output logic                                m_halted,
    output logic [1:0]                          m_status
);

    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW  = $clog2(STACK_DEPTH);
    localparam int unsigned DW  = smc_pkg::DATA_W;
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_ONE  = SPW'(1);
    localparam logic [SPW-1:0] SP_TWO  = SPW'(2);
    localparam logic [SPW-1:0] SP_THREE = SPW'(3);

    logic [SPW-1:0]        sp_reg, sp_next, ex_sp;
    logic [DW-1:0]         tos_reg, tos_next, ex_tos;
    logic [DW-1:0]         nos_reg, nos_next, ex_nos;
    logic                  halt_reg, halt_next, ex_halt;
    smc_pkg::status_t      cause_reg, cause_next, ex_cause, ex_status;

    logic                  s_fire;
    logic [DW-1:0]         t_val, n_val, r_val, third_q;
    logic [DW-1:0]         push_val, alu_res;
    logic                  push_en, ex_ovf, ex_outv, ex_we;
    logic [7:0]            ex_outc;
    logic [SPW-1:0]        sp_m2, sp_next_m3;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_out_valid_reg;
    logic [7:0]            m_out_char_reg;
    logic [DW-1:0]         m_top_value_reg;
    logic [SPW-1:0]        m_depth_reg;
    logic                  m_halted_reg;
    smc_pkg::status_t      m_status_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign t_val = (sp_reg != '0)     ? tos_reg : '0;
    assign n_val = (sp_reg >= SP_TWO)   ? nos_reg : '0;
    assign r_val = (sp_reg >= SP_THREE) ? third_q : '0;
    assign sp_m2 = sp_reg - SP_TWO;

    always_comb begin
        ex_sp    = sp_reg;
        ex_tos   = t_val;
        ex_nos   = n_val;
        ex_halt  = halt_reg;
        ex_cause = cause_reg;
        ex_ovf   = 1'b0;
        ex_outv  = 1'b0;
        ex_outc  = '0;
        ex_we    = 1'b0;
        push_en  = 1'b0;
        push_val = '0;
        alu_res  = '0;
        if (!halt_reg) begin
            unique case (s_kind)
                smc_pkg::OPC_BIPUSH: begin
                    push_en  = 1'b1;
                    push_val = {{(DW-8){s_operand[7]}}, s_operand};
                end
                smc_pkg::OPC_DUP: begin
                    push_en  = 1'b1;
                    push_val = t_val;
                end
                smc_pkg::OPC_IN: begin
                    push_en  = 1'b1;
                    push_val = s_in_eof ? '0 : {{(DW-8){1'b0}}, s_in_char};
                end
                smc_pkg::OPC_IADD, smc_pkg::OPC_ISUB,
                smc_pkg::OPC_IAND, smc_pkg::OPC_IOR: begin
                    unique case (s_kind)
                        smc_pkg::OPC_IADD: alu_res = n_val + t_val;
                        smc_pkg::OPC_ISUB: alu_res = n_val - t_val;
                        smc_pkg::OPC_IAND: alu_res = n_val & t_val;
                        default:           alu_res = n_val | t_val;
                    endcase
                    ex_tos = alu_res;
                    ex_nos = r_val;
                    ex_sp  = (sp_reg < SP_TWO) ? SP_ONE : sp_reg - SP_ONE;
                end
                smc_pkg::OPC_POP, smc_pkg::OPC_OUT: begin
                    if (sp_reg != '0) begin
                        ex_tos = n_val;
                        ex_nos = r_val;
                        ex_sp  = sp_reg - SP_ONE;
                    end
                    if (s_kind == smc_pkg::OPC_OUT) begin
                        ex_outv = 1'b1;
                        ex_outc = t_val[7:0];
                    end
                end
                smc_pkg::OPC_SWAP: begin
                    ex_tos = n_val;
                    ex_nos = t_val;
                    ex_sp  = (sp_reg < SP_TWO) ? SP_TWO : sp_reg;
                end
                smc_pkg::OPC_NOP: begin
                end
                smc_pkg::OPC_ERR: begin
                    ex_halt  = 1'b1;
                    ex_cause = smc_pkg::ST_ERR;
                end
                smc_pkg::OPC_HALT: begin
                    ex_halt  = 1'b1;
                    ex_cause = smc_pkg::ST_OK;
                end
                default: begin
                    ex_halt  = 1'b1;
                    ex_cause = smc_pkg::ST_UNKNOWN;
                end
            endcase
            if (push_en) begin
                if (sp_reg == SP_FULL) begin
                    ex_ovf = 1'b1;
                end else begin
                    ex_we  = (sp_reg >= SP_TWO);
                    ex_nos = t_val;
                    ex_tos = push_val;
                    ex_sp  = sp_reg + SP_ONE;
                end
            end
        end
        priority if (ex_ovf) begin
            ex_status = smc_pkg::ST_OVERFLOW;
        end else if (ex_halt) begin
            ex_status = ex_cause;
        end else begin
            ex_status = smc_pkg::ST_OK;
        end
    end

    assign sp_next    = s_fire ? ex_sp    : sp_reg;
    assign tos_next   = s_fire ? ex_tos   : tos_reg;
    assign nos_next   = s_fire ? ex_nos   : nos_reg;
    assign halt_next  = s_fire ? ex_halt  : halt_reg;
    assign cause_next = s_fire ? ex_cause : cause_reg;
    assign sp_next_m3 = sp_next - SP_THREE;
    assign m_valid_next = s_fire || (m_valid_reg && !m_ready);

    smc_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .aclk  (aclk),
        .we    (s_fire && ex_we),
        .waddr (sp_m2[AW-1:0]),
        .wdata (nos_reg),
        .raddr (sp_next_m3[AW-1:0]),
        .rdata (third_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            halt_reg    <= 1'b0;
            cause_reg   <= smc_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            sp_reg      <= sp_next;
            halt_reg    <= halt_next;
            cause_reg   <= cause_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        nos_reg <= nos_next;
        if (s_fire) begin
            m_out_valid_reg <= ex_outv;
            m_out_char_reg  <= ex_outc;
            m_top_value_reg <= (ex_sp == '0) ? '0 : ex_tos;
            m_depth_reg     <= ex_sp;
            m_halted_reg    <= ex_halt;
            m_status_reg    <= ex_status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_valid = m_out_valid_reg;
    assign m_out_char  = m_out_char_reg;
    assign m_top_value = m_top_value_reg;
    assign m_depth     = m_depth_reg;
    assign m_halted    = m_halted_reg;
    assign m_status    = m_status_reg;

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond depth");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    a_halted_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && halt_reg) |=> ($stable(sp_reg) && $stable(cause_reg)))
        else $error("state changed while halted");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == smc_pkg::ST_OVERFLOW) |-> (m_depth_reg == SP_FULL))
        else $error("overflow reported below full depth");

    a_out_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_out_valid_reg) |-> !m_halted_reg)
        else $error("output character while halted");

endmodule

// ===== bench/tb_stack_machine_core_unit.sv =====
// Testbench for stack_machine_core_unit: random instruction streams checked against a predictor.
`timescale 1ns / 100ps

module tb_stack_machine_core_unit;

    localparam int unsigned STACK_DEPTH = 256;

    typedef struct {
        logic [7:0]        kind;
        logic signed [7:0] operand;
        logic [7:0]        in_char;
        logic              in_eof;
    } instr_t;

    typedef struct {
        logic             out_valid;
        logic [7:0]       out_char;
        logic [31:0]      top_value;
        logic [8:0]       depth;
        logic             halted;
        smc_pkg::status_t status;
    } result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_kind = 8'h00;
    logic signed [7:0] s_operand = 8'sh00;
    logic [7:0]        s_in_char = 8'h00;
    logic              s_in_eof = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_out_valid;
    logic [7:0]        m_out_char;
    logic signed [31:0] m_top_value;
    logic [8:0]        m_depth;
    logic              m_halted;
    logic [1:0]        m_status;

    stack_machine_core_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_operand(s_operand),
        .s_in_char(s_in_char),
        .s_in_eof(s_in_eof),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_valid(m_out_valid),
        .m_out_char(m_out_char),
        .m_top_value(m_top_value),
        .m_depth(m_depth),
        .m_halted(m_halted),
        .m_status(m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    instr_t      pending_instrs[$];
    result_t     predicted_results[$];
    instr_t      cur_instr;
    result_t     next_result;
    result_t     want;

    // predictor state
    logic [31:0]      stack_words [STACK_DEPTH];
    int unsigned      stack_ptr = 0;
    bit               halt_q = 1'b0;
    smc_pkg::status_t halt_why = smc_pkg::ST_OK;
    bit               ovf_now = 1'b0;

    int unsigned n_total = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_out_chars = 0;
    int unsigned n_overflows = 0;
    int unsigned n_errors = 0;
    int unsigned idle_left = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;

    function automatic logic [31:0] pop_word();
        if (stack_ptr == 0)
            return 32'd0;
        stack_ptr--;
        return stack_words[stack_ptr];
    endfunction

    function automatic void push_word(input logic [31:0] v);
        if (stack_ptr >= STACK_DEPTH) begin
            ovf_now = 1'b1;
        end else begin
            stack_words[stack_ptr] = v;
            stack_ptr++;
        end
    endfunction

    function automatic logic [31:0] top_word();
        if (stack_ptr == 0)
            return 32'd0;
        return stack_words[stack_ptr - 1];
    endfunction

    task automatic exec_instr(input instr_t it, output result_t r);
        logic [31:0] a;
        logic [31:0] b;
        r.out_valid = 1'b0;
        r.out_char = 8'h00;
        ovf_now = 1'b0;
        if (!halt_q) begin
            case (it.kind)
                smc_pkg::OPC_BIPUSH: push_word({{24{it.operand[7]}}, it.operand});
                smc_pkg::OPC_DUP: push_word(top_word());
                smc_pkg::OPC_IADD: begin
                    b = pop_word(); a = pop_word(); push_word(a + b);
                end
                smc_pkg::OPC_ISUB: begin
                    b = pop_word(); a = pop_word(); push_word(a - b);
                end
                smc_pkg::OPC_IAND: begin
                    b = pop_word(); a = pop_word(); push_word(a & b);
                end
                smc_pkg::OPC_IOR: begin
                    b = pop_word(); a = pop_word(); push_word(a | b);
                end
                smc_pkg::OPC_POP: a = pop_word();
                smc_pkg::OPC_SWAP: begin
                    a = pop_word(); b = pop_word(); push_word(a); push_word(b);
                end
                smc_pkg::OPC_NOP: ;
                smc_pkg::OPC_IN: push_word(it.in_eof ? 32'd0 : {24'd0, it.in_char});
                smc_pkg::OPC_OUT: begin
                    a = pop_word();
                    r.out_valid = 1'b1;
                    r.out_char = a[7:0];
                end
                smc_pkg::OPC_ERR: begin
                    halt_q = 1'b1; halt_why = smc_pkg::ST_ERR;
                end
                smc_pkg::OPC_HALT: begin
                    halt_q = 1'b1; halt_why = smc_pkg::ST_OK;
                end
                default: begin
                    halt_q = 1'b1; halt_why = smc_pkg::ST_UNKNOWN;
                end
            endcase
        end
        r.top_value = top_word();
        r.depth = stack_ptr[8:0];
        r.halted = halt_q;
        if (ovf_now)
            r.status = smc_pkg::ST_OVERFLOW;
        else if (halt_q)
            r.status = halt_why;
        else
            r.status = smc_pkg::ST_OK;
    endtask

    // mostly short gaps, a few long ones, none during a calm stretch
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_left != 0 || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_op(input int unsigned grow_pct,
                                           input int unsigned keep_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < grow_pct) begin
            case ($urandom_range(0, 2))
                0: return smc_pkg::OPC_BIPUSH;
                1: return smc_pkg::OPC_IN;
                default: return smc_pkg::OPC_DUP;
            endcase
        end
        if (r < grow_pct + keep_pct)
            return ($urandom_range(0, 1) != 0) ? smc_pkg::OPC_SWAP : smc_pkg::OPC_NOP;
        case ($urandom_range(0, 5))
            0: return smc_pkg::OPC_POP;
            1: return smc_pkg::OPC_OUT;
            2: return smc_pkg::OPC_IADD;
            3: return smc_pkg::OPC_ISUB;
            4: return smc_pkg::OPC_IAND;
            default: return smc_pkg::OPC_IOR;
        endcase
    endfunction

    task automatic add_instr(input logic [7:0] k, input logic [7:0] opnd,
                             input logic [7:0] ch, input logic eof);
        instr_t it;
        it.kind = k;
        it.operand = opnd;
        it.in_char = ch;
        it.in_eof = eof;
        pending_instrs.push_back(it);
    endtask

    task automatic add_rand(input logic [7:0] k);
        add_instr(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 3) == 0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h", n_results, what, got, exp_val);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        if (calm_left != 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(0, 199) == 0)
            calm_left <= $urandom_range(30, 120);
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            idle_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                exec_instr(cur_instr, next_result);
                predicted_results.push_back(next_result);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (idle_left != 0) begin
                    s_valid <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (pending_instrs.size() != 0) begin
                    cur_instr = pending_instrs.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= cur_instr.kind;
                    s_operand <= cur_instr.operand;
                    s_in_char <= cur_instr.in_char;
                    s_in_eof <= cur_instr.in_eof;
                    idle_left <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected result", m_top_value, 32'd0);
                end else begin
                    want = predicted_results.pop_front();
                    if (m_out_valid !== want.out_valid)
                        report_mismatch("out_valid", 32'(m_out_valid), 32'(want.out_valid));
                    if (m_out_char !== want.out_char)
                        report_mismatch("out_char", 32'(m_out_char), 32'(want.out_char));
                    if (m_top_value !== want.top_value)
                        report_mismatch("top_value", m_top_value, want.top_value);
                    if (m_depth !== want.depth)
                        report_mismatch("depth", 32'(m_depth), 32'(want.depth));
                    if (m_halted !== want.halted)
                        report_mismatch("halted", 32'(m_halted), 32'(want.halted));
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (want.out_valid)
                        n_out_chars++;
                    if (want.status == smc_pkg::ST_OVERFLOW)
                        n_overflows++;
                end
                n_results++;
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_ready <= 1'b1;
                if (m_ready)
                    stall_left <= pick_gap();
            end
        end
    end

    initial begin
        int unsigned i;
        int unsigned ending;
        logic [7:0] k;
        bit known;

        // empty-stack pops, one-entry swap and binary op, sign extension, eof
        add_rand(smc_pkg::OPC_POP);
        add_rand(smc_pkg::OPC_OUT);
        add_rand(smc_pkg::OPC_IAND);
        add_rand(smc_pkg::OPC_POP);
        add_rand(smc_pkg::OPC_DUP);
        add_rand(smc_pkg::OPC_POP);
        add_instr(smc_pkg::OPC_BIPUSH, 8'h7F, 8'h00, 1'b0);
        add_rand(smc_pkg::OPC_SWAP);
        add_rand(smc_pkg::OPC_POP);
        add_rand(smc_pkg::OPC_IADD);
        add_instr(smc_pkg::OPC_BIPUSH, 8'h80, 8'h00, 1'b0);
        add_rand(smc_pkg::OPC_ISUB);
        add_instr(smc_pkg::OPC_IN, 8'h00, 8'hFF, 1'b0);
        add_instr(smc_pkg::OPC_IN, 8'hFF, 8'hA5, 1'b1);
        add_instr(smc_pkg::OPC_BIPUSH, 8'hFF, 8'hFF, 1'b1);
        add_rand(smc_pkg::OPC_IOR);
        add_rand(smc_pkg::OPC_IAND);
        add_rand(smc_pkg::OPC_DUP);
        add_rand(smc_pkg::OPC_ISUB);
        add_instr(smc_pkg::OPC_BIPUSH, 8'h00, 8'h00, 1'b0);
        add_rand(smc_pkg::OPC_SWAP);
        add_rand(smc_pkg::OPC_NOP);
        add_rand(smc_pkg::OPC_OUT);
        add_rand(smc_pkg::OPC_OUT);
        add_rand(smc_pkg::OPC_IADD);

        for (i = 0; i < 40; i++)
            add_rand(pick_op(45, 15));

        // fill past full, then ops on a full stack
        i = 0;
        while (i < 268) begin
            k = pick_op(92, 8);
            add_rand(k);
            if (k == smc_pkg::OPC_BIPUSH || k == smc_pkg::OPC_IN || k == smc_pkg::OPC_DUP)
                i++;
        end
        add_rand(smc_pkg::OPC_SWAP);
        add_rand(smc_pkg::OPC_IADD);
        add_rand(smc_pkg::OPC_DUP);
        add_rand(smc_pkg::OPC_DUP);
        add_rand(smc_pkg::OPC_IN);
        add_rand(smc_pkg::OPC_BIPUSH);

        // drain past empty
        i = 0;
        while (i < 272) begin
            k = pick_op(0, 5);
            add_rand(k);
            if (k != smc_pkg::OPC_SWAP && k != smc_pkg::OPC_NOP)
                i++;
        end

        for (i = 0; i < 30; i++)
            add_rand(pick_op(50, 15));

        ending = $urandom_range(0, 2);
        if (ending == 0) begin
            add_rand(smc_pkg::OPC_HALT);
        end else if (ending == 1) begin
            add_rand(smc_pkg::OPC_ERR);
        end else begin
            do begin
                k = 8'($urandom_range(0, 255));
                case (k)
                    smc_pkg::OPC_NOP, smc_pkg::OPC_BIPUSH, smc_pkg::OPC_POP,
                    smc_pkg::OPC_DUP, smc_pkg::OPC_SWAP, smc_pkg::OPC_IADD,
                    smc_pkg::OPC_ISUB, smc_pkg::OPC_IAND, smc_pkg::OPC_IOR,
                    smc_pkg::OPC_IN, smc_pkg::OPC_OUT, smc_pkg::OPC_ERR,
                    smc_pkg::OPC_HALT: known = 1'b1;
                    default: known = 1'b0;
                endcase
            end while (known);
            add_rand(k);
        end
        // ignored once halted
        for (i = 0; i < 6; i++)
            add_rand(pick_op(50, 10));
        n_total = pending_instrs.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted != n_total || predicted_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Ran %0d instructions, checked %0d results: %0d OUT chars, %0d overflows",
                 n_accepted, n_results, n_out_chars, n_overflows);
        $display("Stack filled to %0d and drained; run ended with halt cause %0d",
                 STACK_DEPTH, halt_why);
        if (n_errors == 0 && predicted_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, predicted_results.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d of %0d instructions accepted", n_accepted, n_total);
        $display("TEST FAILED");
        $finish;
    end

endmodule
